// ----- src/sdtq_pkg.sv -----
// Package for the sorted deadline timer queue.
// Holds the sizing constants, the item and table entry types and the state codes.
// No dependencies.
`default_nettype none

package sdtq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_RESULTS = 16;
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int POP_W = $clog2(MAX_RESULTS + 1);

	typedef enum logic [0:0] {
		ACT_TICK  = 1'b0,
		ACT_START = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		KIND_EXPIRED  = 2'd0,
		KIND_ACCEPTED = 2'd1,
		KIND_REJECTED = 2'd2
	} kind_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  handler_id;
		logic [7:0]  task_id;
		logic [31:0] duration;
	} cmd_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] expired_handler;
		logic [7:0] expired_task;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [63:0] deadline;
		logic [7:0]  handler;
		logic [7:0]  owner;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_POP
	} state_t;

endpackage

`default_nettype wire

// ----- src/sorted_deadline_timer_queue.sv -----
// Top level of the sorted deadline timer queue.
// Depends on sdtq_pkg for constants and types.
//
// Usage: an item is taken on cmd at a rising edge where start is high and
// busy is low. A tick item advances the 64-bit tick count by one and then
// expires, in deadline order, every table entry that is due, up to
// MAX_RESULTS of them. A start item stores a timer at deadline = count +
// duration behind any entries with an equal deadline.
// Results appear on result with result_valid high for exactly one cycle; the
// receiver cannot stall them, and there is no back-pressure on this side.
// Timing: a start on a full table gives its rejection in the cycle after it
// is taken. Otherwise a start scans the table with one 64-bit comparator,
// one entry a cycle, past the entries at or before the new deadline, and
// its result appears as busy drops. A tick gives one result a cycle for its
// expiries; each expiry waits in the pending register until another entry
// is popped or the tick ends. The same comparator checks the head of the
// table against the count, and busy stays high until the scan or the
// expiries are done, so no new item is taken before then.
// Reset clears the tick count, the entry count and the sequencer; the table
// storage itself is not cleared, since only entries below the count are read.
`default_nettype none

module sorted_deadline_timer_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire sdtq_pkg::cmd_t  cmd,
	output logic                 busy,
	output logic                 result_valid,
	output sdtq_pkg::result_t    result
);
	import sdtq_pkg::*;

	state_t            state_q, state_d;
	logic [63:0]       tick_q;
	logic [63:0]       deadline_q;
	logic [7:0]        handler_q;
	logic [7:0]        owner_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [POP_W-1:0]  pops_q;
	logic [7:0]        pend_handler_q;
	logic [7:0]        pend_owner_q;
	logic              have_pend_q;
	entry_t            entries_q [QUEUE_DEPTH];
	logic              result_valid_q;
	result_t           result_q;

	logic              accept;
	logic              full;
	logic [IDX_W-1:0]  idx_sel;
	logic [63:0]       cmp_ref;
	logic              cmp_le;
	logic              in_range;
	logic              scan_step;
	logic              do_insert;
	logic              do_pop;
	logic              finish;
	entry_t            new_entry;

	assign accept    = start && (state_q == ST_IDLE);
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign new_entry = '{deadline: deadline_q, handler: handler_q, owner: owner_q};

	// The single shared comparator: a table entry against either the new
	// deadline while scanning, or the tick count when checking the head.
	assign idx_sel  = (state_q == ST_SCAN) ? idx_q[IDX_W-1:0] : '0;
	assign cmp_ref  = (state_q == ST_SCAN) ? deadline_q : tick_q;
	assign cmp_le   = (entries_q[idx_sel].deadline <= cmp_ref);
	assign in_range = (state_q == ST_SCAN) ? (idx_q < count_q) : (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		scan_step = 1'b0;
		do_insert = 1'b0;
		do_pop    = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd.action == ACT_START) begin
						if (!full) begin
							state_d = ST_SCAN;
						end
					end else begin
						state_d = ST_POP;
					end
				end
			end
			ST_SCAN: begin
				if (in_range && cmp_le) begin
					scan_step = 1'b1;
				end else begin
					do_insert = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_POP: begin
				if (in_range && cmp_le && (pops_q < POP_W'(MAX_RESULTS))) begin
					do_pop = 1'b1;
				end else begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control and result registers. An expired entry is held back in the
	// pending register so that its last marker is known when it leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q         <= '0;
			count_q        <= '0;
			idx_q          <= '0;
			pops_q         <= '0;
			have_pend_q    <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			if (accept) begin
				if (cmd.action == ACT_START) begin
					idx_q <= '0;
					if (full) begin
						result_valid_q <= 1'b1;
						result_q       <= '{KIND_REJECTED, 8'd0, 8'd0, 1'b1};
					end
				end else begin
					tick_q      <= tick_q + 64'd1;
					pops_q      <= '0;
					have_pend_q <= 1'b0;
				end
			end
			if (scan_step) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (do_insert) begin
				count_q        <= count_q + CNT_W'(1);
				result_valid_q <= 1'b1;
				result_q       <= '{KIND_ACCEPTED, 8'd0, 8'd0, 1'b1};
			end
			if (do_pop) begin
				count_q     <= count_q - CNT_W'(1);
				pops_q      <= pops_q + POP_W'(1);
				have_pend_q <= 1'b1;
				if (have_pend_q) begin
					result_valid_q <= 1'b1;
					result_q <= '{KIND_EXPIRED, pend_handler_q, pend_owner_q, 1'b0};
				end
			end
			if (finish && have_pend_q) begin
				result_valid_q <= 1'b1;
				result_q       <= '{KIND_EXPIRED, pend_handler_q, pend_owner_q, 1'b1};
			end
		end
	end

	// Payload registers: the new timer, the pending expiry and the table.
	always_ff @(posedge clk) begin
		if (accept && (cmd.action == ACT_START)) begin
			deadline_q <= tick_q + {32'd0, cmd.duration};
			handler_q  <= cmd.handler_id;
			owner_q    <= cmd.task_id;
		end
		if (do_pop) begin
			pend_handler_q <= entries_q[0].handler;
			pend_owner_q   <= entries_q[0].owner;
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				entries_q[i] <= entries_q[i + 1];
			end
		end
		if (do_insert) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (CNT_W'(i) == idx_q) begin
					entries_q[i] <= new_entry;
				end
			end
			for (int i = 1; i < QUEUE_DEPTH; i++) begin
				if (CNT_W'(i) > idx_q) begin
					entries_q[i] <= entries_q[i - 1];
				end
			end
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count exceeds the table depth");

	a_start_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && (result_q.kind != KIND_EXPIRED) |-> result_q.last)
		else $error("start result without last marker");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> (count_q == $past(count_q) + CNT_W'(1)) && result_valid_q)
		else $error("insertion did not grow the table or report");

	a_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |-> (count_q != '0) && (state_q == ST_POP))
		else $error("expiry from an empty table");

endmodule

`default_nettype wire
